// ===== src/exposure_luminance_estimator_unit_macros.svh =====
// Assertion macros used by the estimator top level.
`ifndef EXPOSURE_LUMINANCE_ESTIMATOR_UNIT_MACROS_SVH
`define EXPOSURE_LUMINANCE_ESTIMATOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off during reset.
`define ELU_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");
// Next-cycle implication, sampled on clk, off during reset.
`define ELU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ELU_ASSERT_IMPL(lbl, ante, cons)
`define ELU_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== src/elu_pkg.sv =====
// Types and constants of the exposure and luminance estimator.
package elu_pkg;

  localparam logic [16:0] CLK_RESET   = 17'd26000;
  localparam logic [15:0] LEVEL_RECIP = 16'd56680;  // ceil(2^22 / 74)
  localparam int          LEVEL_SHIFT = 22;
  localparam logic [21:0] MIN_GAIN    = 22'd64;
  localparam logic [8:0]  VLONG_DIV   = 9'd500;
  // s / 500 = (s / 4) / 125, exact for any 30-bit quotient input
  localparam logic [30:0] VLONG_RECIP = 31'd1099511628;  // ceil(2^37 / 125)
  localparam int          VLONG_SHIFT = 37;

  // Luminance numerators per shutter range
  localparam logic [27:0] A_TINY  = 28'd253890;
  localparam logic [27:0] A_SHORT = 28'd1015625;
  localparam logic [27:0] A_MID   = 28'd4062500;
  localparam logic [27:0] A_LONG  = 28'd260000000;
  localparam logic [27:0] A_VLONG = 28'd65000000;

  localparam logic [31:0] LIM_TINY  = 32'd4;
  localparam logic [31:0] LIM_SHORT = 32'd16;
  localparam logic [31:0] LIM_MID   = 32'd1024;
  localparam logic [31:0] LIM_LONG  = 32'd131072;

  typedef enum logic [2:0] {
    BR_TINY, BR_SHORT, BR_MID, BR_LONG, BR_VLONG
  } br_t;

  typedef struct packed {
    logic [9:0]  b;
    logic [21:0] g;
  } pay_bg_t;

  typedef struct packed {
    logic [31:0] s;
    logic [9:0]  b;
    logic [21:0] g;
  } pay_sbg_t;

  typedef struct packed {
    br_t         br;
    logic [31:0] s;
    logic [9:0]  b;
    logic [21:0] g;
  } pay_a_t;

  typedef struct packed {
    br_t         br;
    logic [31:0] s;
    logic [21:0] g;
  } pay_l_t;

endpackage

// ===== src/elu_if.sv =====
// Stream interfaces: register snapshot in, estimate out.
interface elu_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] level_reg;
  logic [15:0] gain_reg;
  logic [15:0] digital_gain_reg;
  logic [15:0] read_mode_reg;
  logic [15:0] width_reg;
  logic [15:0] blank_reg;
  logic [15:0] integration_reg;
  modport source (output valid, level_reg, gain_reg, digital_gain_reg, read_mode_reg,
                  width_reg, blank_reg, integration_reg, input ready);
  modport sink (input valid, level_reg, gain_reg, digital_gain_reg, read_mode_reg,
                width_reg, blank_reg, integration_reg, output ready);
endinterface

interface elu_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] luminance;
  logic [31:0] luminance_fraction;
  logic [31:0] shutter;
  logic [31:0] gain;
  modport source (output valid, luminance, luminance_fraction, shutter, gain, input ready);
  modport sink (input valid, luminance, luminance_fraction, shutter, gain, output ready);
endinterface

// ===== src/elu_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module elu_div #(
  parameter int NW = 32,
  parameter int DW = 32,
  parameter int PW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [PW-1:0] in_pay,
  output logic          out_valid,
  output logic [NW-1:0] out_quo,
  output logic [PW-1:0] out_pay
);

  logic          valid_r [NW];
  logic [DW-1:0] rem_r   [NW];
  logic [NW-1:0] acc_r   [NW];
  logic [DW-1:0] den_r   [NW];
  logic [PW-1:0] pay_r   [NW];

  logic          v_src   [NW];
  logic [DW-1:0] rem_src [NW];
  logic [NW-1:0] acc_src [NW];
  logic [DW-1:0] den_src [NW];
  logic [PW-1:0] pay_src [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DW:0] trial;
    logic        ge;

    // stage source: ports for the first stage, previous stage otherwise
    if (k == 0) begin : g_first
      assign v_src[k]   = in_valid;
      assign rem_src[k] = '0;
      assign acc_src[k] = in_num;
      assign den_src[k] = in_den;
      assign pay_src[k] = in_pay;
    end else begin : g_next
      assign v_src[k]   = valid_r[k-1];
      assign rem_src[k] = rem_r[k-1];
      assign acc_src[k] = acc_r[k-1];
      assign den_src[k] = den_r[k-1];
      assign pay_src[k] = pay_r[k-1];
    end

    // bring down one numerator bit, try the subtract
    assign trial = {rem_src[k], acc_src[k][NW-1]};
    assign ge    = trial >= {1'b0, den_src[k]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else if (en) begin
        valid_r[k] <= v_src[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? DW'(trial - {1'b0, den_src[k]}) : trial[DW-1:0];
        acc_r[k] <= {acc_src[k][NW-2:0], ge};
        den_r[k] <= den_src[k];
        pay_r[k] <= pay_src[k];
      end
    end
  end

  assign out_valid = valid_r[NW-1];
  assign out_quo   = acc_r[NW-1];
  assign out_pay   = pay_r[NW-1];

endmodule

// ===== src/exposure_luminance_estimator_unit.sv =====
// Top level of the exposure and luminance estimator.
// Usage:
//   in_if  (sink): one beat carries a snapshot of the seven sensor registers.
//   out_if (source): one beat per snapshot with luminance, fraction, shutter
//     and gain, in the order the snapshots came in.
//   cfg_we/cfg_data: writes the master clock in kHz; write only while idle.
// Pipeline: an accepted input beat reaches out_if.valid through two 32-stage
//   bit-per-stage dividers (shutter, then luminance and fraction side by
//   side) plus a 28-stage divider for the range numerator, a one-stage
//   reciprocal multiply for shutter/500, six single-stage arithmetic steps
//   and the output register.
// Throughput: one beat per cycle while out_if.ready stays high.
// Stall: when the output register holds a beat that is not taken, the whole
//   pipeline freezes and in_if.ready drops; nothing is lost or repeated.
// Reset: rst_n (synchronous, active low) clears all valid bits and sets the
//   master clock to 26000 kHz.
`include "exposure_luminance_estimator_unit_macros.svh"

module exposure_luminance_estimator_unit (
  input  logic        clk,
  input  logic        rst_n,
  elu_in_if.sink      in_if,
  elu_out_if.source   out_if,
  input  logic        cfg_we,
  input  logic [16:0] cfg_data
);
  import elu_pkg::*;

  logic        en;
  logic [16:0] clk_khz_r;

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clk_khz_r <= CLK_RESET;
    end else if (cfg_we) begin
      clk_khz_r <= cfg_data;
    end
  end

  // global advance: the output register is free or being drained
  logic out_valid_r;
  assign en          = !out_valid_r || out_if.ready;
  assign in_if.ready = en;

  // ---- stage 1: line length times rows, brightness, gain factors ----
  logic        s1_valid_r;
  logic [31:0] s1_lr_r;
  logic        s1_pm4_r;
  logic [9:0]  s1_b_r;
  logic [10:0] s1_m_r;
  logic [15:0] s1_dig_r;

  logic [17:0] line;
  logic [33:0] lr_full;
  logic [31:0] b_full;
  logic [2:0]  dbl_cnt;

  always_comb begin
    line = 18'((|in_if.read_mode_reg[3:2]) ? (in_if.width_reg >> 1) : in_if.width_reg)
           + 18'd8 + 18'(in_if.blank_reg);
    lr_full = line * in_if.integration_reg;
    b_full  = in_if.level_reg * LEVEL_RECIP;
    dbl_cnt = 3'(in_if.gain_reg[7]) + 3'(in_if.gain_reg[8])
            + 3'(in_if.gain_reg[9]) + 3'(in_if.gain_reg[10]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_lr_r  <= lr_full[31:0];
      s1_pm4_r <= in_if.read_mode_reg[10];
      s1_b_r   <= b_full[LEVEL_SHIFT +: 10];
      s1_m_r   <= 11'(in_if.gain_reg[6:0]) << dbl_cnt;
      s1_dig_r <= in_if.gain_reg[15:0] == 16'd0 ? 16'd0 :
                  in_if.digital_gain_reg[7:0] * in_if.digital_gain_reg[15:8];
    end
  end

  // ---- stage 2: shutter numerator and clamped gain ----
  logic        s2_valid_r;
  logic [31:0] s2_num_r;
  pay_bg_t     s2_pay_r;

  logic [31:0] lr_sh;
  logic [41:0] num_full;
  logic [26:0] gp;
  logic [21:0] gt;

  always_comb begin
    lr_sh    = s1_pm4_r ? {s1_lr_r[29:0], 2'b00} : {s1_lr_r[30:0], 1'b0};
    num_full = lr_sh * 10'd1000;
    gp       = s1_m_r * s1_dig_r;
    gt       = gp[26:5];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_num_r   <= num_full[31:0];
      s2_pay_r.b <= s1_b_r;
      s2_pay_r.g <= (gt < MIN_GAIN) ? MIN_GAIN : gt;
    end
  end

  // ---- shutter division by the master clock ----
  logic        ds_valid;
  logic [31:0] ds_quo;
  logic [31:0] ds_pay;

  elu_div #(.NW(32), .DW(17), .PW($bits(pay_bg_t))) u_div_shutter (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (s2_valid_r),
    .in_num   (s2_num_r),
    .in_den   (clk_khz_r),
    .in_pay   (s2_pay_r),
    .out_valid(ds_valid),
    .out_quo  (ds_quo),
    .out_pay  (ds_pay)
  );

  // ---- stage 3: shutter floor of one ----
  logic     s3_valid_r;
  pay_sbg_t s3_pay_r;
  pay_bg_t  ds_bg;

  assign ds_bg = pay_bg_t'(ds_pay);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (en) begin
      s3_valid_r <= ds_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_pay_r.s <= (ds_quo == 32'd0) ? 32'd1 : ds_quo;
      s3_pay_r.b <= ds_bg.b;
      s3_pay_r.g <= ds_bg.g;
    end
  end

  // ---- shutter / 500 for the longest range: (s / 4) times reciprocal of 125 ----
  logic        d5_valid_r;
  logic [60:0] d5_prod_r;
  pay_sbg_t    d5_pay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d5_valid_r <= 1'b0;
    end else if (en) begin
      d5_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d5_prod_r <= s3_pay_r.s[31:2] * VLONG_RECIP;
      d5_pay_r  <= s3_pay_r;
    end
  end

  // ---- stage 4: range decode, numerator and divisor select ----
  logic        s4_valid_r;
  logic [27:0] s4_anum_r;
  logic [31:0] s4_aden_r;
  pay_a_t      s4_pay_r;

  pay_sbg_t    d5_p;
  logic [31:0] d5_quo;
  br_t         br;
  logic [27:0] anum;

  assign d5_p   = d5_pay_r;
  assign d5_quo = {8'd0, d5_prod_r[60:VLONG_SHIFT]};

  always_comb begin
    priority if (d5_p.s < LIM_TINY) begin
      br = BR_TINY;
    end else if (d5_p.s < LIM_SHORT) begin
      br = BR_SHORT;
    end else if (d5_p.s < LIM_MID) begin
      br = BR_MID;
    end else if (d5_p.s < LIM_LONG) begin
      br = BR_LONG;
    end else begin
      br = BR_VLONG;
    end
    unique case (br)
      BR_TINY:  anum = A_TINY;
      BR_SHORT: anum = A_SHORT;
      BR_MID:   anum = A_MID;
      BR_LONG:  anum = A_LONG;
      default:  anum = A_VLONG;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else if (en) begin
      s4_valid_r <= d5_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_anum_r   <= anum;
      s4_aden_r   <= (br == BR_VLONG) ? d5_quo : d5_p.s;
      s4_pay_r.br <= br;
      s4_pay_r.s  <= d5_p.s;
      s4_pay_r.b  <= d5_p.b;
      s4_pay_r.g  <= d5_p.g;
    end
  end

  // ---- range numerator divided by shutter ----
  logic                      da_valid;
  logic [27:0]               da_quo;
  logic [$bits(pay_a_t)-1:0] da_pay;

  elu_div #(.NW(28), .DW(32), .PW($bits(pay_a_t))) u_div_a (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (s4_valid_r),
    .in_num   (s4_anum_r),
    .in_den   (s4_aden_r),
    .in_pay   (s4_pay_r),
    .out_valid(da_valid),
    .out_quo  (da_quo),
    .out_pay  (da_pay)
  );

  // ---- stage 5: brightness times range factor ----
  logic        s5_valid_r;
  logic [31:0] s5_p_r;
  pay_l_t      s5_pay_r;

  pay_a_t      da_p;
  logic [37:0] p_full;

  assign da_p   = pay_a_t'(da_pay);
  assign p_full = da_p.b * da_quo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_valid_r <= 1'b0;
    end else if (en) begin
      s5_valid_r <= da_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_p_r      <= p_full[31:0];
      s5_pay_r.br <= da_p.br;
      s5_pay_r.s  <= da_p.s;
      s5_pay_r.g  <= da_p.g;
    end
  end

  // ---- stage 6: luminance divisor and fraction numerator ----
  logic        s6_valid_r;
  logic [31:0] s6_p_r;
  logic [31:0] s6_ld_r;
  logic [31:0] s6_fn_r;
  logic        s6_fen_r;
  pay_l_t      s6_pay_r;

  logic [31:0] ld;
  logic [31:0] fn;
  logic [39:0] p250;
  logic [30:0] g500;

  always_comb begin
    p250 = s5_p_r * 8'd250;
    g500 = s5_pay_r.g * VLONG_DIV;
    unique case (s5_pay_r.br)
      BR_TINY, BR_SHORT: begin
        ld = 32'(s5_pay_r.g);
        fn = '0;
      end
      BR_MID: begin
        ld = 32'(s5_pay_r.g >> 4);
        fn = '0;
      end
      BR_LONG: begin
        ld = {8'd0, s5_pay_r.g, 2'b00};
        fn = p250[31:0];
      end
      default: begin
        ld = 32'(g500);
        fn = {s5_p_r[30:0], 1'b0};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_valid_r <= 1'b0;
    end else if (en) begin
      s6_valid_r <= s5_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_p_r   <= s5_p_r;
      s6_ld_r  <= ld;
      s6_fn_r  <= fn;
      s6_fen_r <= (s5_pay_r.br == BR_LONG) || (s5_pay_r.br == BR_VLONG);
      s6_pay_r <= s5_pay_r;
    end
  end

  // ---- luminance and fraction divisions side by side ----
  logic                      dl_valid;
  logic [31:0]               dl_quo;
  logic [$bits(pay_l_t)-1:0] dl_pay;
  logic                      df_valid;
  logic [31:0]               df_quo;
  logic                      df_fen;

  elu_div #(.NW(32), .DW(32), .PW($bits(pay_l_t))) u_div_lum (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (s6_valid_r),
    .in_num   (s6_p_r),
    .in_den   (s6_ld_r),
    .in_pay   (s6_pay_r),
    .out_valid(dl_valid),
    .out_quo  (dl_quo),
    .out_pay  (dl_pay)
  );

  elu_div #(.NW(32), .DW(22), .PW(1)) u_div_frac (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (s6_valid_r),
    .in_num   (s6_fn_r),
    .in_den   (s6_pay_r.g),
    .in_pay   (s6_fen_r),
    .out_valid(df_valid),
    .out_quo  (df_quo),
    .out_pay  (df_fen)
  );

  // ---- output register: range scaling and fraction ----
  logic [31:0] out_lum_r;
  logic [31:0] out_frac_r;
  logic [31:0] out_s_r;
  logic [21:0] out_g_r;

  pay_l_t      dl_p;
  logic [31:0] lum;
  logic [41:0] lum_k;

  assign dl_p = pay_l_t'(dl_pay);

  always_comb begin
    unique case (dl_p.br)
      BR_TINY:  lum = {dl_quo[23:0], 8'd0};
      BR_SHORT: lum = {dl_quo[25:0], 6'd0};
      default:  lum = dl_quo;
    endcase
    lum_k = lum * 10'd1000;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dl_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_lum_r  <= lum;
      out_frac_r <= (df_fen && (lum < 32'd50)) ? (df_quo - lum_k[31:0]) : 32'd0;
      out_s_r    <= dl_p.s;
      out_g_r    <= dl_p.g;
    end
  end

  assign out_if.valid              = out_valid_r;
  assign out_if.luminance          = out_lum_r;
  assign out_if.luminance_fraction = out_frac_r;
  assign out_if.shutter            = out_s_r;
  assign out_if.gain               = 32'(out_g_r);

  // ---- checks ----
  `ELU_ASSERT_IMPL(a_gain_floor, out_valid_r, out_g_r >= MIN_GAIN)
  `ELU_ASSERT_IMPL(a_shutter_nonzero, out_valid_r, out_s_r != 32'd0)
  `ELU_ASSERT_IMPL(a_div_lanes_aligned, 1'b1, dl_valid == df_valid)
  `ELU_ASSERT_IMPL(a_frac_small_lum, out_valid_r && (out_frac_r != 32'd0),
                   out_lum_r < 32'd50)
  `ELU_ASSERT_NEXT(a_stall_freezes, out_valid_r && !out_if.ready,
                   out_valid_r && $stable(out_lum_r) && $stable(out_s_r))

endmodule
